### sv/chained_hash_table_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chained hash table
// Both macros clock on i_clk and stay quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define CHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cht_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_pkg
// Shared widths, codes and beat types of the chained hash table.
// ---------------------------------------------------------------------------
package cht_pkg;

    localparam int KEY_W    = 31;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int FILL_W   = 4;

    // Key bits folded into the remainder per step of the hash unit
    localparam int DIGIT_W  = 4;

    localparam int BUCKETS_DEF      = 13;
    localparam int BUCKET_DEPTH_DEF = 8;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    bucket_index;
        logic [FILL_W-1:0]   bucket_fill;
    } t_rsp;

endpackage

### sv/cht_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cht_mod.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cht_mod
// Iterative key modulo constant: folds DIGIT_W key bits per cycle.
// ---------------------------------------------------------------------------
module cht_mod #(
    parameter int DIVISOR = cht_pkg::BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cht_pkg::KEY_W-1:0]  i_key,
    output logic                       o_done,
    output logic [$clog2(DIVISOR)-1:0] o_rem
);

    localparam int RemW   = $clog2(DIVISOR);
    localparam int Digits = (cht_pkg::KEY_W + cht_pkg::DIGIT_W - 1) / cht_pkg::DIGIT_W;
    localparam int PadW   = Digits * cht_pkg::DIGIT_W;
    localparam int CntW   = $clog2(Digits + 1);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [PadW-1:0] r_work;
    logic [RemW-1:0] r_rem;
    logic [RemW-1:0] n_rem;

    // One digit: shift in each bit, subtract the divisor once when reached
    always_comb begin
        logic [RemW:0] t;
        n_rem = r_rem;
        for (int i = 0; i < cht_pkg::DIGIT_W; i++) begin
            t = {n_rem, r_work[PadW-1-i]};
            if (t >= (RemW+1)'(DIVISOR)) begin
                t = t - (RemW+1)'(DIVISOR);
            end
            n_rem = t[RemW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CntW'(Digits - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= PadW'(i_key);
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_work <= r_work << cht_pkg::DIGIT_W;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + CntW'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### sv/chained_hash_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_hash_table_top
// Bounded chained hash table: insert, search and remove of 31-bit keys.
// ---------------------------------------------------------------------------
// Usage
//   Request channel: i_req_valid / o_req_ready carry one beat of t_req
//   (mode, key). Response channel: o_rsp_valid / i_rsp_ready carry one beat
//   of t_rsp (status, bucket_index, bucket_fill) for every request.
//   After a request is accepted, its key goes through the modulo unit
//   (eight 4-bit digits, then its done flag), then the bucket base step,
//   a scan of the BUCKET_DEPTH slots through the one key RAM read port
//   and a write-back step, where the response is loaded. o_req_ready is
//   high only when idle, so one request is in flight and the next is
//   taken only after write-back. After reset the valid-bit RAM is swept
//   to zero, one bucket row per cycle; o_req_ready stays low during the
//   sweep.
//   The response sits in an output register, so a new request is taken
//   while an old response is still waiting. If the receiver stalls, the
//   next request holds in write-back until the output register frees up.
// ---------------------------------------------------------------------------
module chained_hash_table_top #(
    parameter int BUCKETS      = cht_pkg::BUCKETS_DEF,
    parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  cht_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output cht_pkg::t_rsp o_rsp
);

    `include "chained_hash_table_top_assert.svh"

    localparam int BW    = $clog2(BUCKETS);
    localparam int SlotW = $clog2(BUCKET_DEPTH + 1);
    localparam int Total = BUCKETS * BUCKET_DEPTH;
    localparam int AddrW = $clog2(Total);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_BASE  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    // Control state
    logic [2:0]    r_state, n_state;
    logic [BW-1:0] r_clr, n_clr;
    logic          r_rsp_valid, n_rsp_valid;

    // Request and scan payload
    logic [cht_pkg::MODE_W-1:0] r_mode;
    logic [cht_pkg::KEY_W-1:0]  r_key;
    logic [BW-1:0]              r_bucket;
    logic [AddrW-1:0]           r_base;
    logic [SlotW-1:0]           r_slot;
    logic [BUCKET_DEPTH-1:0]    r_row;
    logic [BUCKET_DEPTH-1:0]    r_shift;
    logic [SlotW-1:0]           r_fill;
    logic                       r_hit;
    logic [SlotW-1:0]           r_match;
    logic                       r_free_vld;
    logic [SlotW-1:0]           r_free;
    cht_pkg::t_rsp              r_rsp;

    // Hash unit
    logic          mod_done;
    logic [BW-1:0] mod_rem;

    // RAM ports
    logic                      key_we;
    logic [AddrW-1:0]          key_waddr;
    logic [AddrW-1:0]          key_raddr;
    logic [cht_pkg::KEY_W-1:0] key_rdata;
    logic                      row_we;
    logic [BW-1:0]             row_waddr;
    logic [BUCKET_DEPTH-1:0]   row_wdata;
    logic [BUCKET_DEPTH-1:0]   row_rdata;

    // Decision
    logic                         accept;
    logic                         load;
    logic [SlotW-1:0]             cmp_slot;
    logic [cht_pkg::STATUS_W-1:0] rsp_status;
    logic [SlotW-1:0]             fill_out;
    logic [BUCKET_DEPTH-1:0]      new_row;
    logic                         ins_ok;
    logic                         rem_ok;
    logic [cht_pkg::IDX_W+BW-1:0]     idx_ext;
    logic [cht_pkg::FILL_W+SlotW-1:0] fill_ext;
    logic [AddrW+SlotW-1:0]           rd_sum;
    logic [AddrW+SlotW-1:0]           wr_sum;
    cht_pkg::t_rsp                    rsp_next;

    assign accept      = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign load        = (r_state == S_WRITE) && (!r_rsp_valid || i_rsp_ready);
    assign cmp_slot    = r_slot - SlotW'(1);

    cht_mod #(
        .DIVISOR (BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_req.key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Key store: one entry per slot, never cleared
    cht_ram #(
        .WIDTH (cht_pkg::KEY_W),
        .DEPTH (Total)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // Valid bits: one row per bucket, swept to zero after reset
    cht_ram #(
        .WIDTH (BUCKET_DEPTH),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (r_bucket),
        .o_rdata (row_rdata)
    );

    // Advance the key read address one slot per scan cycle
    assign rd_sum    = (AddrW+SlotW)'(r_base) + (AddrW+SlotW)'(r_slot);
    assign key_raddr = rd_sum[AddrW-1:0];

    // Insert goes to the lowest free slot
    assign wr_sum    = (AddrW+SlotW)'(r_base) + (AddrW+SlotW)'(r_free);
    assign key_waddr = wr_sum[AddrW-1:0];

    assign ins_ok = (r_mode == cht_pkg::MODE_INSERT) && !r_hit && r_free_vld;
    assign rem_ok = (r_mode == cht_pkg::MODE_REMOVE) && r_hit;

    always_comb begin
        new_row  = r_row;
        fill_out = r_fill;
        if (ins_ok) begin
            new_row  = r_row | (BUCKET_DEPTH'(1) << r_free);
            fill_out = r_fill + SlotW'(1);
        end else if (rem_ok) begin
            new_row  = r_row & ~(BUCKET_DEPTH'(1) << r_match);
            fill_out = r_fill - SlotW'(1);
        end
    end

    always_comb begin
        case (r_mode)
            cht_pkg::MODE_INSERT: begin
                if (r_hit) begin
                    rsp_status = cht_pkg::ST_DUP;
                end else if (!r_free_vld) begin
                    rsp_status = cht_pkg::ST_FULL;
                end else begin
                    rsp_status = cht_pkg::ST_DONE;
                end
            end
            // Search, remove and the unused mode code: the unused code behaves as a search
            default: begin
                rsp_status = r_hit ? cht_pkg::ST_DONE : cht_pkg::ST_MISS;
            end
        endcase
    end

    assign idx_ext  = (cht_pkg::IDX_W+BW)'(r_bucket);
    assign fill_ext = (cht_pkg::FILL_W+SlotW)'(fill_out);

    always_comb begin
        rsp_next.status       = rsp_status;
        rsp_next.bucket_index = idx_ext[cht_pkg::IDX_W-1:0];
        rsp_next.bucket_fill  = fill_ext[cht_pkg::FILL_W-1:0];
    end

    assign key_we    = load && ins_ok;
    assign row_we    = (r_state == S_CLEAR) || (load && (ins_ok || rem_ok));
    assign row_waddr = (r_state == S_CLEAR) ? r_clr : r_bucket;
    assign row_wdata = (r_state == S_CLEAR) ? '0 : new_row;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        if (load) begin
            n_rsp_valid = 1'b1;
        end
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + BW'(1);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_slot == SlotW'(BUCKET_DEPTH)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload path: no reset, every field is set before it is used
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_req.mode;
            r_key  <= i_req.key;
        end
        if (r_state == S_HASH && mod_done) begin
            r_bucket <= mod_rem;
        end
        if (r_state == S_BASE) begin
            r_base     <= AddrW'(r_bucket * BUCKET_DEPTH);
            r_slot     <= '0;
            r_fill     <= '0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (r_slot == '0) begin
                // Capture the bucket's valid row
                r_row   <= row_rdata;
                r_shift <= row_rdata;
            end else begin
                // Check the slot whose key arrives this cycle
                if (r_shift[0]) begin
                    r_fill <= r_fill + SlotW'(1);
                    if (!r_hit && key_rdata == r_key) begin
                        r_hit   <= 1'b1;
                        r_match <= cmp_slot;
                    end
                end else if (!r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free     <= cmp_slot;
                end
                r_shift <= r_shift >> 1;
            end
            if (r_slot != SlotW'(BUCKET_DEPTH)) begin
                r_slot <= r_slot + SlotW'(1);
            end
        end
        if (load) begin
            r_rsp <= rsp_next;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Checks
    `CHT_ASSERT_NXT(a_busy_after_accept, accept, !o_req_ready, "ready after accept")
    `CHT_ASSERT_IMP(a_scan_complete, r_state == S_WRITE, r_slot == SlotW'(BUCKET_DEPTH), "write-back before scan end")
    `CHT_ASSERT_IMP(a_fill_bound, r_state == S_WRITE, r_fill <= SlotW'(BUCKET_DEPTH), "fill above depth")
    `CHT_ASSERT_IMP(a_key_write_insert, key_we, r_mode == cht_pkg::MODE_INSERT && !r_hit, "key write without insert")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chained hash table testbench
// Drives insert, search and remove requests into chained_hash_table_top and
// checks every response against a local model of the bucket table. Requests
// come in random bursts and the response side stalls on its own pattern.
// ---------------------------------------------------------------------------
module testbench;

    import cht_pkg::*;

    localparam int NB      = BUCKETS_DEF;
    localparam int NDEPTH  = BUCKET_DEPTH_DEF;
    localparam int MAX_KEY = 32'h7fff_ffff;

    // The fourth mode code has no name in the package; the block treats it
    // as a search.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // The slowest beat adds a sender gap and a receiver stall to the work of
    // the block; about 830 beats plus the reset sweep fit within CYCLE_LIMIT
    // many times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS = 40;

    // -----------------------------------------------------------------------
    // Clock, reset and block I/O
    // -----------------------------------------------------------------------
    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    always #5 i_clk = ~i_clk;

    chained_hash_table_top #(
        .BUCKETS      (NB),
        .BUCKET_DEPTH (NDEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // -----------------------------------------------------------------------
    // Local copy of the bucket table
    // Slot keys are only looked at where the valid bit is set.
    // -----------------------------------------------------------------------
    logic [KEY_W-1:0] slot_key   [NB][NDEPTH];
    logic             slot_taken [NB][NDEPTH];

    t_rsp predicted_rsp_q [$];
    int   mismatch_cnt = 0;
    int   cycle_cnt    = 0;

    // Work out the response to one request and update the table as the
    // block would: first matching slot, lowest free slot, fill after the op.
    function automatic t_rsp hash_table_apply(t_req req);
        logic [31:0]         bkt;
        int                  hit;
        int                  free_s;
        logic [31:0]         fill;
        logic [STATUS_W-1:0] st;
        t_rsp                rsp;
        bkt    = req.key % NB;
        hit    = -1;
        free_s = -1;
        fill   = 0;
        for (int s = 0; s < NDEPTH; s++) begin
            if (slot_taken[bkt][s]) begin
                fill++;
                if (hit < 0 && slot_key[bkt][s] == req.key)
                    hit = s;
            end else if (free_s < 0) begin
                free_s = s;
            end
        end
        case (req.mode)
            MODE_INSERT: begin
                if (hit >= 0) begin
                    st = ST_DUP;
                end else if (free_s < 0) begin
                    st = ST_FULL;
                end else begin
                    slot_key[bkt][free_s]   = req.key;
                    slot_taken[bkt][free_s] = 1'b1;
                    fill++;
                    st = ST_DONE;
                end
            end
            MODE_REMOVE: begin
                if (hit >= 0) begin
                    slot_taken[bkt][hit] = 1'b0;
                    fill--;
                    st = ST_DONE;
                end else begin
                    st = ST_MISS;
                end
            end
            default: begin
                // search, and the spare mode which behaves the same
                st = (hit >= 0) ? ST_DONE : ST_MISS;
            end
        endcase
        rsp.status       = st;
        rsp.bucket_index = bkt[IDX_W-1:0];
        rsp.bucket_fill  = fill[FILL_W-1:0];
        return rsp;
    endfunction

    // -----------------------------------------------------------------------
    // Request side
    // Beats go out in bursts; between bursts valid drops for a random gap.
    // -----------------------------------------------------------------------
    bit sender_gaps_on = 1'b1;
    int burst_left     = 0;

    task automatic issue_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key);
        t_req req;
        int   gap;
        req.mode = mode;
        req.key  = key;
        // raise valid and hold the payload until the beat is taken
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (!o_req_ready);
        predicted_rsp_q = {predicted_rsp_q, hash_table_apply(req)};
        if (sender_gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // -----------------------------------------------------------------------
    // Response side: stall pattern and checking
    // Ready alternates between runs of acceptance and stalls of mixed
    // length. Sampled values are the ones from before the edge.
    // -----------------------------------------------------------------------
    bit rsp_stalls_on = 1'b1;
    int ready_run     = 0;

    always @(posedge i_clk) begin
        t_rsp want;
        if (o_rsp_valid && i_rsp_ready) begin
            if (predicted_rsp_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: response with nothing outstanding: status %0d idx %0d fill %0d",
                             $time, o_rsp.status, o_rsp.bucket_index, o_rsp.bucket_fill);
            end else begin
                want = predicted_rsp_q.pop_front();
                if (o_rsp.status !== want.status
                        || o_rsp.bucket_index !== want.bucket_index
                        || o_rsp.bucket_fill !== want.bucket_fill) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: expected %0d %0d %0d, actual %0d %0d %0d",
                                 $time, want.status, want.bucket_index, want.bucket_fill,
                                 o_rsp.status, o_rsp.bucket_index, o_rsp.bucket_fill);
                end
            end
        end

        // advance the stall pattern
        if (!rsp_stalls_on) begin
            i_rsp_ready <= 1'b1;
            ready_run   = 0;
        end else if (ready_run > 0) begin
            ready_run--;
        end else if (i_rsp_ready) begin
            i_rsp_ready <= 1'b0;
            ready_run   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(5, 25);
        end else begin
            i_rsp_ready <= 1'b1;
            ready_run   = $urandom_range(0, 10);
        end
    end

    // Watchdog: end the run with a mismatch when cycle_cnt reaches CYCLE_LIMIT, whether or not responses still come.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("chained_hash_table_top: mismatch");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Key helpers
    // -----------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] key_in_bucket(int unsigned bkt);
        int unsigned m;
        m = $urandom_range(0, (MAX_KEY - bkt) / NB);
        return KEY_W'(m * NB + bkt);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)      return MODE_INSERT;
        else if (r < 65) return MODE_SEARCH;
        else if (r < 95) return MODE_REMOVE;
        else             return MODE_SPARE;
    endfunction

    // Keys crowd a few hot buckets so that they fill up and overflow;
    // the rest are scattered.
    logic [KEY_W-1:0] key_pool [$];

    task automatic build_key_pool();
        int unsigned hot [3];
        key_pool.delete();
        foreach (hot[h])
            hot[h] = $urandom_range(0, NB - 1);
        foreach (hot[h])
            repeat (NDEPTH + 4) key_pool = {key_pool, key_in_bucket(hot[h])};
        repeat (20) key_pool = {key_pool, key_in_bucket($urandom_range(0, NB - 1))};
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Extremes of the key, each mode, duplicates, misses, a full bucket and
    // slot reuse after a remove.
    task automatic test_directed();
        logic [KEY_W-1:0] crowd [NDEPTH + 1];
        logic [KEY_W-1:0] top_key;
        top_key = KEY_W'(MAX_KEY);
        foreach (crowd[i])
            crowd[i] = key_in_bucket(5);

        issue_request(MODE_INSERT, '0);
        issue_request(MODE_SEARCH, '0);
        issue_request(MODE_INSERT, '0);
        issue_request(MODE_SPARE,  '0);
        issue_request(MODE_REMOVE, '0);
        issue_request(MODE_REMOVE, '0);
        issue_request(MODE_SEARCH, '0);

        issue_request(MODE_INSERT, top_key);
        issue_request(MODE_SPARE,  top_key);
        issue_request(MODE_REMOVE, top_key);

        // fill one bucket, then one more key than it holds
        foreach (crowd[i])
            issue_request(MODE_INSERT, crowd[i]);
        // duplicate into a full bucket reports the duplicate, not full
        issue_request(MODE_INSERT, crowd[2]);
        // free a middle slot and take it again
        issue_request(MODE_REMOVE, crowd[3]);
        issue_request(MODE_INSERT, crowd[NDEPTH]);
        issue_request(MODE_SEARCH, crowd[NDEPTH]);
    endtask

    // Mostly pool keys with random ops, some insert/search/remove/search
    // runs on one key, and a little noise with full-width keys.
    task automatic test_hot_buckets(int n_items);
        int               sent;
        int unsigned      r;
        logic [KEY_W-1:0] k;
        build_key_pool();
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if (r < 70) begin
                issue_request(pick_mode(), k);
                sent++;
            end else if (r < 90) begin
                issue_request(MODE_INSERT, k);
                issue_request(MODE_SEARCH, k);
                issue_request(MODE_REMOVE, k);
                issue_request(MODE_SEARCH, k);
                sent += 4;
            end else begin
                issue_request(MODE_W'($urandom_range(0, 3)), KEY_W'($urandom));
                sent++;
            end
        end
    endtask

    // Full-width random keys and modes with no idling on either side.
    task automatic test_wide_keys(int n_items);
        sender_gaps_on = 1'b0;
        rsp_stalls_on  = 1'b0;
        repeat (n_items)
            issue_request(pick_mode(), KEY_W'($urandom));
        sender_gaps_on = 1'b1;
        rsp_stalls_on  = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        foreach (slot_taken[b, s])
            slot_taken[b][s] = 1'b0;

        // hold reset, then release it; the block sweeps its valid bits after
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_hot_buckets(450);
        test_wide_keys(120);
        test_hot_buckets(230);

        i_req_valid <= 1'b0;
        while (predicted_rsp_q.size() != 0)
            @(posedge i_clk);
        // let any stray response show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("chained_hash_table_top: match");
        else
            $display("chained_hash_table_top: mismatch");
        $finish;
    end

endmodule
